// ----- src/vp9hp_pkg.sv -----
// ----------------------------------------------------------------------------
// vp9hp_pkg
// Shared types, codes and bit-step functions for the VP9 header
// profile / bit-depth parser.
// ----------------------------------------------------------------------------
package vp9hp_pkg;

   // Header constants
   localparam logic [23:0] SYNC_CODE    = 24'h498342;
   localparam logic [1:0]  MARKER_VALUE = 2'h2;

   // Register indexes of the configuration port
   localparam logic [7:0] REG_PRESET_PROFILE = 8'd0;
   localparam logic [7:0] REG_PRESET_KNOWN   = 8'd1;
   localparam logic [7:0] REG_PRESET_DEPTH   = 8'd2;
   localparam logic [7:0] REG_CHROMA_CODE    = 8'd3;

   // Parse phase codes
   localparam logic [3:0] PH_MARKER    = 4'd0;
   localparam logic [3:0] PH_PROF0     = 4'd1;
   localparam logic [3:0] PH_PROF1     = 4'd2;
   localparam logic [3:0] PH_PROFRES   = 4'd3;
   localparam logic [3:0] PH_SHOWEX    = 4'd4;
   localparam logic [3:0] PH_FTYPE     = 4'd5;
   localparam logic [3:0] PH_SHOWFRAME = 4'd6;
   localparam logic [3:0] PH_ERRRES    = 4'd7;
   localparam logic [3:0] PH_INTRA     = 4'd8;
   localparam logic [3:0] PH_SYNC      = 4'd9;
   localparam logic [3:0] PH_HBD       = 4'd10;

   // Frame flag bits
   localparam logic [1:0] FLAG_KEY   = 2'b01;
   localparam logic [1:0] FLAG_INVIS = 2'b10;

   // Depth codes
   localparam logic [4:0] DEPTH_8  = 5'd8;
   localparam logic [4:0] DEPTH_10 = 5'd10;
   localparam logic [4:0] DEPTH_12 = 5'd12;

   localparam logic [4:0] SYNC_LAST_COUNT = 5'd23;
   localparam logic [4:0] SYNC_BITS       = 5'd24;
   localparam int         BYTE_BITS       = 8;

   typedef struct packed {
      logic [1:0] preset_profile;
      logic       preset_known;
      logic [4:0] preset_depth;
      logic [1:0] chroma_code;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  phase;
      logic [4:0]  count;
      logic [23:0] shift;
      logic [2:0]  profile;
      logic        known;
      logic [4:0]  depth;
      logic [1:0]  flags;
      logic        stopped;
   } parse_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } in_word_type;

   // One header bit through the parser
   function automatic parse_state_type take_bit(parse_state_type s, logic b);
      parse_state_type n;
      logic [23:0]     sh;
      logic [2:0]      prof;
      n    = s;
      sh   = {s.shift[22:0], b};
      prof = s.profile | {1'b0, b, 1'b0};
      if (!s.stopped) begin
         case (s.phase)
            PH_MARKER: begin
               n.shift = sh;
               n.count = s.count + 5'd1;
               if (s.count != 5'd0) begin
                  if (sh[1:0] != MARKER_VALUE) n.stopped = 1'b1;
                  else n.phase = PH_PROF0;
                  n.count = 5'd0;
                  n.shift = 24'd0;
               end
            end
            PH_PROF0: begin
               n.profile = {2'b00, b};
               n.known   = 1'b1;
               n.phase   = PH_PROF1;
            end
            PH_PROF1: begin
               n.profile = prof;
               n.phase   = (prof == 3'd3) ? PH_PROFRES : PH_SHOWEX;
            end
            PH_PROFRES: begin
               n.profile = s.profile + {2'b00, b};
               n.phase   = PH_SHOWEX;
            end
            PH_SHOWEX: begin
               if (b) n.stopped = 1'b1;
               else n.phase = PH_FTYPE;
            end
            PH_FTYPE: begin
               n.flags = b ? 2'b00 : FLAG_KEY;
               n.phase = PH_SHOWFRAME;
            end
            PH_SHOWFRAME: begin
               if (!b) n.flags = s.flags | FLAG_INVIS;
               n.phase = PH_ERRRES;
            end
            PH_ERRRES: begin
               if ((s.flags & FLAG_KEY) != 2'b00) n.phase = PH_SYNC;
               else if ((s.flags & FLAG_INVIS) != 2'b00) n.phase = PH_INTRA;
               else n.stopped = 1'b1;
               n.count = 5'd0;
               n.shift = 24'd0;
            end
            PH_INTRA: begin
               if (b) n.phase = PH_SYNC;
               else n.stopped = 1'b1;
            end
            PH_SYNC: begin
               n.shift = sh;
               n.count = s.count + 5'd1;
               if (s.count >= SYNC_LAST_COUNT) begin
                  if (sh != SYNC_CODE) begin
                     n.stopped = 1'b1;
                  end else if (s.profile <= 3'd1) begin
                     n.depth   = DEPTH_8;
                     n.stopped = 1'b1;
                  end else begin
                     n.phase = PH_HBD;
                  end
                  n.count = 5'd0;
               end
            end
            PH_HBD: begin
               n.depth   = b ? DEPTH_12 : DEPTH_10;
               n.stopped = 1'b1;
            end
            default: begin
               n.stopped = 1'b1;
            end
         endcase
      end
      return n;
   endfunction

   // Feed zero bits until the parse ends; closed form per phase
   function automatic parse_state_type flush_zeros(parse_state_type s);
      parse_state_type n;
      logic [23:0]     fin;
      logic [4:0]      amt;
      n   = s;
      amt = SYNC_BITS - s.count;
      fin = s.shift << amt;
      if (!s.stopped) begin
         case (s.phase)
            PH_MARKER: begin
               // a pending one completes a good marker, profile reads as zero
               if (s.count != 5'd0 && s.shift[0]) begin
                  n.profile = 3'd0;
                  n.known   = 1'b1;
               end
            end
            PH_PROF0: begin
               n.profile = 3'd0;
               n.known   = 1'b1;
            end
            PH_SYNC: begin
               if (s.count != 5'd0 && fin == SYNC_CODE)
                  n.depth = (s.profile <= 3'd1) ? DEPTH_8 : DEPTH_10;
            end
            PH_HBD: begin
               n.depth = DEPTH_10;
            end
            default: begin
               n.depth = s.depth;
            end
         endcase
         n.stopped = 1'b1;
      end
      return n;
   endfunction

   // Fill in a missing profile from depth and chroma
   function automatic parse_state_type derive_profile(parse_state_type s,
                                                      logic [1:0] chroma);
      parse_state_type n;
      n = s;
      if (!s.known && s.depth != 5'd0) begin
         if (chroma <= 2'd1) n.profile = (s.depth == DEPTH_8) ? 3'd0 : 3'd2;
         else n.profile = (s.depth == DEPTH_8) ? 3'd1 : 3'd3;
         n.known = 1'b1;
      end
      return n;
   endfunction

endpackage

// ----- src/vp9hp_if.sv -----
// ----------------------------------------------------------------------------
// vp9hp channel interfaces
// Byte input, result output and register write channels.
// ----------------------------------------------------------------------------
interface vp9hp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vp9hp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] profile_value;
   logic       profile_valid;
   logic [4:0] depth_value;
   modport source (output valid, output profile_value, output profile_valid,
                   output depth_value, input ready);
   modport sink   (input valid, input profile_value, input profile_valid,
                   input depth_value, output ready);
endinterface

interface vp9hp_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/vp9hp_csr_regs.sv -----
// ----------------------------------------------------------------------------
// vp9hp_csr_regs
// Preset and chroma registers written over the configuration channel.
// ----------------------------------------------------------------------------
module vp9hp_csr_regs
   import vp9hp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   vp9hp_csr_if.sink    csr_chan,
   output cfg_type      cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr;

   assign csr_chan.ready = 1'b1;
   assign wr  = csr_chan.valid;
   assign cfg = cfg_ff;

   // Decode the write; ignore indexes past the list
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_chan.index)
            REG_PRESET_PROFILE: cfg_in.preset_profile = csr_chan.data[1:0];
            REG_PRESET_KNOWN:   cfg_in.preset_known   = csr_chan.data[0];
            REG_PRESET_DEPTH:   cfg_in.preset_depth   = csr_chan.data[4:0];
            REG_CHROMA_CODE:    cfg_in.chroma_code    = csr_chan.data[1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/vp9hp_in_stage.sv -----
// ----------------------------------------------------------------------------
// vp9hp_in_stage
// Input register for one frame byte; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module vp9hp_in_stage
   import vp9hp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   vp9hp_req_if.sink    req_chan,
   input  logic         advance,
   output in_word_type  word
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   // Load a new word or drop the consumed one
   always_comb begin
      valid_in = valid_ff && !advance;
      data_in  = data_ff;
      last_in  = last_ff;
      if (take) begin
         valid_in = 1'b1;
         data_in  = req_chan.data_byte;
         last_in  = req_chan.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign word.valid     = valid_ff;
   assign word.data_byte = data_ff;
   assign word.last_byte = last_ff;

endmodule

// ----- src/vp9hp_parse_core.sv -----
// ----------------------------------------------------------------------------
// vp9hp_parse_core
// Eight header bit steps per byte, end-of-frame flush and profile
// derivation, with the result register.
// ----------------------------------------------------------------------------
module vp9hp_parse_core
   import vp9hp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  in_word_type  word,
   output logic         advance,
   vp9hp_rsp_if.source  rsp_chan
);

   parse_state_type state_ff, state_in;
   logic            open_ff, open_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      prof_ff, prof_in;
   logic            known_ff, known_in;
   logic [4:0]      depth_ff, depth_in;

   parse_state_type start;
   parse_state_type steps [BYTE_BITS+1];
   parse_state_type fin;

   assign advance = word.valid && (!rsp_valid_ff || rsp_chan.ready);

   // Load presets at the first byte of a frame
   always_comb begin
      start = state_ff;
      if (!open_ff) begin
         start.profile = {1'b0, cfg.preset_profile};
         start.known   = cfg.preset_known;
         start.depth   = cfg.preset_depth;
         start.phase   = PH_MARKER;
         start.count   = 5'd0;
         start.shift   = 24'd0;
         start.flags   = 2'b00;
         start.stopped = cfg.preset_known && (cfg.preset_depth != 5'd0);
      end
   end

   // Run the byte through the parser, MSB first
   always_comb begin
      steps[0] = start;
      for (int i = 0; i < BYTE_BITS; i++) begin
         steps[i+1] = take_bit(steps[i], word.data_byte[BYTE_BITS-1-i]);
      end
      fin = derive_profile(flush_zeros(steps[BYTE_BITS]), cfg.chroma_code);
   end

   // Advance frame state and result register
   always_comb begin
      state_in     = state_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      prof_in      = prof_ff;
      known_in     = known_ff;
      depth_in     = depth_ff;
      if (advance) begin
         if (word.last_byte) begin
            state_in     = fin;
            open_in      = 1'b0;
            rsp_valid_in = 1'b1;
            prof_in      = fin.known ? fin.profile : 3'd0;
            known_in     = fin.known;
            depth_in     = fin.depth;
         end else begin
            state_in = steps[BYTE_BITS];
            open_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prof_ff  <= prof_in;
      known_ff <= known_in;
      depth_ff <= depth_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.profile_value = prof_ff;
   assign rsp_chan.profile_valid = known_ff;
   assign rsp_chan.depth_value   = depth_ff;

endmodule

// ----- src/vp9_header_profile_depth_parser.sv -----
// ----------------------------------------------------------------------------
// vp9_header_profile_depth_parser
// Profile and bit-depth extraction from the VP9 uncompressed header.
// ----------------------------------------------------------------------------
// Feed the frame one byte per word, MSB first, with last_byte set on the final
// byte; one result word (profile, profile valid, depth) follows each last
// byte. The block takes one byte every cycle while no result word is held up:
// a byte sits in the input register, all eight header bit steps of it
// resolve in combinational logic, and the result is registered in the output
// register as the last byte leaves the input register. Presets are sampled at
// the first byte of each frame and the chroma code at the last; the header is
// parsed only when the preset profile is unknown or the preset depth is zero.
// ----------------------------------------------------------------------------
module vp9_header_profile_depth_parser
   import vp9hp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   vp9hp_req_if.sink    req_chan,
   vp9hp_rsp_if.source  rsp_chan,
   vp9hp_csr_if.sink    csr_chan
);

   cfg_type     cfg;
   in_word_type word;
   logic        advance;

   vp9hp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   vp9hp_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .word     (word)
   );

   vp9hp_parse_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .word     (word),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- tb/vp9_header_profile_depth_parser_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vp9_header_profile_depth_parser_test
// Feeds directed and random VP9 frame headers byte by byte under several
// preset settings and idle patterns. A header model predicts each result
// word, and a scoreboard checks every returned word against it in order.
// ----------------------------------------------------------------------------
module vp9_header_profile_depth_parser_test;
   import vp9hp_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int REPORT_LIMIT  = 10;
   localparam int FLUSH_BITS    = 48;

   // Chroma codes
   localparam logic [1:0] CHROMA_420A = 2'd0;
   localparam logic [1:0] CHROMA_420B = 2'd1;
   localparam logic [1:0] CHROMA_422  = 2'd2;
   localparam logic [1:0] CHROMA_444  = 2'd3;

   typedef struct packed {
      logic [2:0] profile_value;
      logic       profile_valid;
      logic [4:0] depth_value;
   } hdr_result_type;

   typedef struct {
      logic [3:0]  phase;
      logic [4:0]  count;
      logic [23:0] shift;
      logic [2:0]  profile;
      logic        known;
      logic [4:0]  depth;
      logic [1:0]  flags;
      logic        stopped;
      logic        in_frame;
   } hdr_parse_type;

   logic clock;
   logic reset;

   vp9hp_req_if req_bus ();
   vp9hp_rsp_if rsp_bus ();
   vp9hp_csr_if csr_bus ();

   vp9_header_profile_depth_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Header model state and mirrored presets
   hdr_parse_type  hdr;
   logic [1:0]     cfg_profile;
   logic           cfg_known;
   logic [4:0]     cfg_depth;
   logic [1:0]     cfg_chroma;
   hdr_result_type pending_headers[$];

   // Frame under construction
   logic        frame_bits[$];
   logic [7:0]  frame_bytes[$];

   int req_idle_pct;
   int rsp_stall_pct;
   int rsp_hold_left;
   int quiet_cycles;
   int mismatch_count;
   int unsigned bytes_sent;
   int unsigned frames_sent;
   int unsigned results_checked;
   int unsigned settings_applied;

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   // Header model: one bit through the parse
   function automatic void parse_header_bit(logic b);
      logic [23:0] sh;
      sh = {hdr.shift[22:0], b};
      if (hdr.stopped) return;
      case (hdr.phase)
         PH_MARKER: begin
            hdr.shift = sh;
            hdr.count = hdr.count + 5'd1;
            if (hdr.count >= 5'd2) begin
               if (hdr.shift[1:0] != MARKER_VALUE) hdr.stopped = 1'b1;
               else hdr.phase = PH_PROF0;
               hdr.count = 5'd0;
               hdr.shift = 24'd0;
            end
         end
         PH_PROF0: begin
            hdr.profile = {2'b00, b};
            hdr.known   = 1'b1;
            hdr.phase   = PH_PROF1;
         end
         PH_PROF1: begin
            hdr.profile = hdr.profile | {1'b0, b, 1'b0};
            hdr.phase   = (hdr.profile == 3'd3) ? PH_PROFRES : PH_SHOWEX;
         end
         PH_PROFRES: begin
            hdr.profile = hdr.profile + {2'b00, b};
            hdr.phase   = PH_SHOWEX;
         end
         PH_SHOWEX: begin
            if (b) hdr.stopped = 1'b1;
            else hdr.phase = PH_FTYPE;
         end
         PH_FTYPE: begin
            hdr.flags = b ? 2'b00 : FLAG_KEY;
            hdr.phase = PH_SHOWFRAME;
         end
         PH_SHOWFRAME: begin
            if (!b) hdr.flags = hdr.flags | FLAG_INVIS;
            hdr.phase = PH_ERRRES;
         end
         PH_ERRRES: begin
            if ((hdr.flags & FLAG_KEY) != 2'b00) hdr.phase = PH_SYNC;
            else if ((hdr.flags & FLAG_INVIS) != 2'b00) hdr.phase = PH_INTRA;
            else hdr.stopped = 1'b1;
            hdr.count = 5'd0;
            hdr.shift = 24'd0;
         end
         PH_INTRA: begin
            if (b) hdr.phase = PH_SYNC;
            else hdr.stopped = 1'b1;
         end
         PH_SYNC: begin
            hdr.shift = sh;
            hdr.count = hdr.count + 5'd1;
            if (hdr.count >= SYNC_BITS) begin
               if (hdr.shift != SYNC_CODE) begin
                  hdr.stopped = 1'b1;
               end else if (hdr.profile <= 3'd1) begin
                  hdr.depth   = DEPTH_8;
                  hdr.stopped = 1'b1;
               end else begin
                  hdr.phase = PH_HBD;
               end
               hdr.count = 5'd0;
            end
         end
         PH_HBD: begin
            hdr.depth   = b ? DEPTH_12 : DEPTH_10;
            hdr.stopped = 1'b1;
         end
         default: begin
            hdr.stopped = 1'b1;
         end
      endcase
   endfunction

   // Header model: one accepted byte; queue a result on the last byte
   function automatic void parse_header_byte(logic [7:0] data, logic last);
      hdr_result_type r;
      if (!hdr.in_frame) begin
         hdr.in_frame = 1'b1;
         hdr.profile  = {1'b0, cfg_profile};
         hdr.known    = cfg_known;
         hdr.depth    = cfg_depth;
         hdr.phase    = PH_MARKER;
         hdr.count    = 5'd0;
         hdr.shift    = 24'd0;
         hdr.flags    = 2'b00;
         hdr.stopped  = cfg_known && (cfg_depth != 5'd0);
      end
      for (int i = 7; i >= 0; i--) parse_header_bit(data[i]);
      if (last) begin
         // bits past the end read as zero
         for (int i = 0; i < FLUSH_BITS && !hdr.stopped; i++) parse_header_bit(1'b0);
         // fill a missing profile from depth and chroma
         if (!hdr.known && hdr.depth != 5'd0) begin
            if (cfg_chroma == CHROMA_420A || cfg_chroma == CHROMA_420B)
               hdr.profile = (hdr.depth == DEPTH_8) ? 3'd0 : 3'd2;
            else
               hdr.profile = (hdr.depth == DEPTH_8) ? 3'd1 : 3'd3;
            hdr.known = 1'b1;
         end
         r.profile_value = hdr.known ? hdr.profile : 3'd0;
         r.profile_valid = hdr.known;
         r.depth_value   = hdr.depth;
         pending_headers.push_back(r);
         hdr.in_frame = 1'b0;
      end
   endfunction

   // Predict every byte word the block takes
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         parse_header_byte(req_bus.data_byte, req_bus.last_byte);
   end

   // Mirror register writes; drop unknown indexes
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_PRESET_PROFILE: cfg_profile = csr_bus.data[1:0];
            REG_PRESET_KNOWN:   cfg_known   = csr_bus.data[0];
            REG_PRESET_DEPTH:   cfg_depth   = csr_bus.data[4:0];
            REG_CHROMA_CODE:    cfg_chroma  = csr_bus.data[1:0];
            default: ;
         endcase
      end
   end

   task automatic note_mismatch(input string what, input hdr_result_type want,
                                input hdr_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: expected profile %0d valid %0b depth %0d, got %0d %0b %0d",
                  $time, what, want.profile_value, want.profile_valid,
                  want.depth_value, got.profile_value, got.profile_valid,
                  got.depth_value);
   endtask

   // Compare each result word with the oldest prediction
   always @(posedge clock) begin : check_results
      hdr_result_type got;
      hdr_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.profile_value = rsp_bus.profile_value;
         got.profile_valid = rsp_bus.profile_valid;
         got.depth_value   = rsp_bus.depth_value;
         if (pending_headers.size() == 0) begin
            note_mismatch("unexpected result", '0, got);
         end else begin
            want = pending_headers.pop_front();
            results_checked++;
            if (got.profile_value != want.profile_value ||
                got.profile_valid != want.profile_valid ||
                got.depth_value != want.depth_value)
               note_mismatch("result mismatch", want, got);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Offer one byte word; leave valid high on return
   task automatic push_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Write one register; leave valid high on return
   task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender until every predicted word has come back
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (pending_headers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Load all presets, with an ignored stray index and junk upper data bits
   task automatic apply_settings(input logic [1:0] prof, input logic known,
                                 input logic [4:0] depth, input logic [1:0] chroma);
      quiesce();
      write_reg(8'($urandom_range(255, REG_CHROMA_CODE + 1)), 8'($urandom));
      write_reg(REG_PRESET_PROFILE, {6'($urandom), prof});
      write_reg(REG_PRESET_KNOWN, {7'($urandom), known});
      write_reg(REG_PRESET_DEPTH, {3'($urandom), depth});
      write_reg(REG_CHROMA_CODE, {6'($urandom), chroma});
      csr_bus.valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic void add_bits(logic [31:0] value, int n);
      for (int i = n - 1; i >= 0; i--) frame_bits.push_back(value[i]);
   endfunction

   // Build the uncompressed header bits in stream order
   function automatic void build_header(logic [1:0] prof, logic resv, logic showex,
                                        logic inter, logic visible, logic errres,
                                        logic intra, logic sync_ok, logic hbd);
      logic [23:0] sync_word;
      sync_word = sync_ok ? SYNC_CODE : SYNC_CODE ^ (24'd1 << $urandom_range(23));
      frame_bits.delete();
      add_bits(32'(MARKER_VALUE), 2);
      add_bits(32'(prof[0]), 1);
      add_bits(32'(prof[1]), 1);
      if (prof == 2'd3) add_bits(32'(resv), 1);
      add_bits(32'(showex), 1);
      add_bits(32'(inter), 1);
      add_bits(32'(visible), 1);
      add_bits(32'(errres), 1);
      if (inter && !visible) add_bits(32'(intra), 1);
      add_bits(32'(sync_word), 24);
      add_bits(32'(hbd), 1);
   endfunction

   // Pack the bits into bytes; random filler past the header
   function automatic void pack_frame(int nbytes);
      logic [7:0] b;
      int idx;
      frame_bytes.delete();
      for (int i = 0; i < nbytes; i++) begin
         for (int k = 0; k < 8; k++) begin
            idx = i * 8 + k;
            b[7 - k] = (idx < frame_bits.size()) ? frame_bits[idx] : 1'($urandom);
         end
         frame_bytes.push_back(b);
      end
   endfunction

   function automatic int header_bytes();
      return (frame_bits.size() + 7) / 8;
   endfunction

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++)
         push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic send_bits_frame(input logic [7:0] data);
      frame_bits.delete();
      add_bits(32'(data), 8);
      pack_frame(1);
      send_frame();
   endtask

   // Mostly well-formed headers with random content, some broken or noise
   task automatic random_frame();
      int nbytes;
      int idx;
      if ($urandom_range(99) < 75) begin
         build_header(2'($urandom_range(3)), 1'($urandom_range(1)),
                      $urandom_range(99) < 8, $urandom_range(99) < 35,
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom_range(99) < 80, $urandom_range(99) < 85,
                      1'($urandom_range(1)));
         if ($urandom_range(99) < 5) begin
            idx = $urandom_range(1);
            frame_bits[idx] = ~frame_bits[idx];
         end
         nbytes = header_bytes() + $urandom_range(3);
         // cut the frame short now and then
         if ($urandom_range(99) < 20) nbytes = $urandom_range(header_bytes(), 1);
      end else begin
         frame_bits.delete();
         nbytes = $urandom_range(6, 1);
      end
      pack_frame(nbytes);
      send_frame();
   endtask

   task automatic run_frames(input int unsigned budget);
      int unsigned target;
      target = bytes_sent + budget;
      while (bytes_sent < target) random_frame();
   endtask

   // Reset presets: profile unknown and depth zero, so every frame is parsed
   task automatic test_directed_headers();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      // bad markers and a one-byte frame that runs into the sync code
      send_bits_frame(8'h00);
      send_bits_frame(8'hFF);
      send_bits_frame(8'h80);
      // keyframe, profile 0, good sync: depth 8
      build_header(2'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      pack_frame(header_bytes());
      send_frame();
      // profile 3 with reserved bit, high bit depth
      build_header(2'd3, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
      pack_frame(header_bytes());
      send_frame();
      // invisible intra-only frame, profile 2: depth 10
      build_header(2'd2, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      pack_frame(header_bytes());
      send_frame();
      // show-existing set
      build_header(2'd1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      pack_frame(1);
      send_frame();
      // visible inter frame
      build_header(2'd2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
      pack_frame(1);
      send_frame();
      // invisible inter frame, intra-only clear
      build_header(2'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      pack_frame(2);
      send_frame();
      // sync mismatch keeps the preset depth
      build_header(2'd1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      pack_frame(header_bytes());
      send_frame();
   endtask

   // Walk the presets through their extremes
   task automatic test_register_settings();
      apply_settings(2'd3, 1'b1, 5'd12, CHROMA_444);
      run_frames(45);
      apply_settings(2'd0, 1'b1, 5'd31, CHROMA_420A);
      run_frames(45);
      apply_settings(2'd1, 1'b0, 5'd31, CHROMA_420A);
      run_frames(45);
      apply_settings(2'd2, 1'b0, DEPTH_8, CHROMA_420B);
      run_frames(45);
      apply_settings(2'd0, 1'b0, 5'd16, CHROMA_422);
      run_frames(45);
      apply_settings(2'd0, 1'b1, 5'd0, CHROMA_444);
      run_frames(45);
      apply_settings(2'd3, 1'b0, DEPTH_10, CHROMA_444);
      run_frames(45);
      apply_settings(2'd2, 1'b1, DEPTH_8, CHROMA_420A);
      run_frames(45);
   endtask

   task automatic apply_random_settings();
      logic [4:0] depth;
      case ($urandom_range(4))
         0, 1: depth = 5'd0;
         2: depth = DEPTH_8;
         3: depth = $urandom_range(1) ? DEPTH_10 : DEPTH_12;
         default: depth = 5'($urandom_range(31, 1));
      endcase
      apply_settings(2'($urandom), $urandom_range(99) < 40, depth, 2'($urandom));
   endtask

   // Random frames under each idle pattern
   task automatic test_random_frames();
      int sender_pct[4] = '{0, 72, 0, 33};
      int receiver_pct[4] = '{0, 0, 72, 33};
      for (int p = 0; p < 4; p++) begin
         apply_random_settings();
         req_idle_pct  = sender_pct[p];
         rsp_stall_pct = receiver_pct[p];
         run_frames(360);
      end
   endtask

   // Long receiver hold-off while one-byte frames keep coming
   task automatic test_backpressure();
      apply_settings(2'd0, 1'b0, 5'd0, CHROMA_420A);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) begin
         frame_bits.delete();
         pack_frame(1);
         send_frame();
      end
      // pause the sender until every result is back
      quiesce();
      rsp_stall_pct = 33;
      run_frames(60);
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'd0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = 8'd0;
      csr_bus.data      = 8'd0;
      hdr               = '{default: '0};
      cfg_profile       = 2'd0;
      cfg_known         = 1'b0;
      cfg_depth         = 5'd0;
      cfg_chroma        = CHROMA_420A;
      req_idle_pct      = 0;
      rsp_stall_pct     = 0;
      rsp_hold_left     = 0;
      quiet_cycles      = 0;
      mismatch_count    = 0;
      bytes_sent        = 0;
      frames_sent       = 0;
      results_checked   = 0;
      settings_applied  = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_headers();
      test_register_settings();
      test_random_frames();
      test_backpressure();

      rsp_stall_pct = 0;
      quiesce();
      $display("covered %0d frames in %0d bytes under %0d preset settings",
               frames_sent, bytes_sent, settings_applied);
      $display("checked %0d result words, %0d mismatches", results_checked,
               mismatch_count);
      if (mismatch_count == 0 && pending_headers.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
